// ===== rtl/core/tdm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the trellis weight decode matvec block.
// No dependencies; every other file in rtl/core imports this package.
package tdm_pkg;

  // Fixed geometry
  localparam int TILE_DIM          = 16;
  localparam int TABLE_ENTRIES     = 1024;
  localparam int VECTOR_DEPTH_DEF  = 4096;
  localparam int LANES             = TILE_DIM / 2;
  localparam int POS_W             = $clog2(TILE_DIM);

  // Field widths
  localparam int TIDX_W  = $clog2(TABLE_ENTRIES);
  localparam int VIDX_W  = 12;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 8;
  localparam int ROWS_W  = 64;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 48;

  // Datapath widths
  localparam int WSC_W   = WORD_W + SCALE_W + 1;   // entry times scale
  localparam int FRAC_SH = 8;                      // Q8.8 scale fraction
  localparam int WGT_W   = WSC_W - FRAC_SH;        // scaled weight
  localparam int PROD_W  = WGT_W + WORD_W;         // weight times element
  localparam int NODE_W  = SUM_W + 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  localparam logic signed [NODE_W-1:0] SUM_MAX =
    {{(NODE_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [NODE_W-1:0] SUM_MIN =
    {{(NODE_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_TABLE  = 2'd0,
    KIND_VECTOR = 2'd1,
    KIND_ROW    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [TIDX_W-1:0]        table_index;
    logic signed [WORD_W-1:0] table_first_value;
    logic signed [WORD_W-1:0] table_second_value;
    logic [VIDX_W-1:0]        vector_index;
    logic signed [WORD_W-1:0] vector_value;
    logic [ROWS_W-1:0]        row_words;
    logic [BYTE_W-1:0]        next_row_high_byte;
    logic [ROW_W-1:0]         row_in_tile;
    logic [COL_W-1:0]         column;
    logic                     last_column;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic signed [SUM_W-1:0] row_sum;
  } result_t;

  // Per-lane stage enables and write strobes
  typedef struct packed {
    logic en_idx;
    logic en_mem;
    logic en_scale;
    logic en_mult;
    logic tbl_we;
    logic vec_we;
  } lane_ctl_t;

  // Write transaction data, shared by all lanes
  typedef struct packed {
    logic [TIDX_W-1:0] tidx;
    logic [WORD_W-1:0] tfirst;
    logic [WORD_W-1:0] tsecond;
    logic [VIDX_W-1:0] vidx;
    logic [WORD_W-1:0] vval;
  } wr_t;

  // Saturating-add chain folded as clamp(x + a, l, h)
  typedef struct packed {
    logic signed [NODE_W-1:0] a;
    logic signed [NODE_W-1:0] l;
    logic signed [NODE_W-1:0] h;
  } node_t;

  function automatic logic signed [NODE_W-1:0] clamp(
    input logic signed [NODE_W-1:0] x,
    input logic signed [NODE_W-1:0] lo,
    input logic signed [NODE_W-1:0] hi
  );
    logic signed [NODE_W-1:0] r;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    else r = x;
    return r;
  endfunction

  function automatic node_t leaf(input logic [PROD_W-1:0] p);
    node_t n;
    n.a = NODE_W'($signed(p));
    n.l = SUM_MIN;
    n.h = SUM_MAX;
    return n;
  endfunction

  // Apply first, then second
  function automatic node_t combine(input node_t first, input node_t second);
    node_t n;
    n.a = first.a + second.a;
    n.l = clamp(first.l + second.a, second.l, second.h);
    n.h = clamp(first.h + second.a, second.l, second.h);
    return n;
  endfunction

endpackage

// ===== rtl/core/tdm_lane.sv =====
// One decode lane: trellis state, table index, local table copy, two vector banks,
// weight scaling and the two products of one state. Depends on tdm_pkg.
module tdm_lane
  import tdm_pkg::*;
#(
  parameter int LANE         = 0,
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  item_t                    item,
  input  wr_t                      wr,
  input  logic [COL_W-1:0]         col,
  input  logic [SCALE_W-1:0]       scale,
  output logic signed [PROD_W-1:0] prod_first,
  output logic signed [PROD_W-1:0] prod_second
);

  localparam int W          = LANE / 2;
  localparam int BANK_DEPTH = (VECTOR_DEPTH + TILE_DIM - 1) / TILE_DIM;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [POS_W-1:0] EVEN_POS = POS_W'(2 * LANE);
  localparam logic [POS_W-1:0] ODD_POS  = POS_W'(2 * LANE + 1);

  logic [WORD_W-1:0] state;
  logic [WORD_W-1:0] sq;
  logic [TIDX_W-1:0] idx;

  logic [WORD_W-1:0] tbl_first  [TABLE_ENTRIES];
  logic [WORD_W-1:0] tbl_second [TABLE_ENTRIES];
  logic [WORD_W-1:0] bank_even  [BANK_DEPTH];
  logic [WORD_W-1:0] bank_odd   [BANK_DEPTH];

  logic [WORD_W-1:0] entry_first, entry_second, vec_even, vec_odd;
  logic              even_ok, odd_ok;

  logic signed [WSC_W-1:0]  wsc_first, wsc_second;
  logic signed [WORD_W-1:0] ve, vo;
  logic signed [WGT_W-1:0]  wgt_first, wgt_second;

  // Build this lane's trellis state
  generate
    if (LANE % 2 == 0) begin : g_even
      assign state = item.row_words[WORD_W*W +: WORD_W];
    end else if (W == 3) begin : g_wrap
      assign state = {item.row_words[WORD_W*W +: BYTE_W], item.next_row_high_byte};
    end else begin : g_odd
      assign state = {item.row_words[WORD_W*W +: BYTE_W],
                      item.row_words[WORD_W*(W+1) + BYTE_W +: BYTE_W]};
    end
  endgenerate

  // Table index from bits 15:6 of the 16-bit s*(s+1)
  assign sq = WORD_W'(state * (state + WORD_W'(1)));

  always_ff @(posedge clk) begin
    if (ctl.en_idx) idx <= sq[WORD_W-1 -: TIDX_W];
  end

  // Table copy: write in order with reads
  always_ff @(posedge clk) begin
    if (ctl.tbl_we) begin
      tbl_first[wr.tidx]  <= wr.tfirst;
      tbl_second[wr.tidx] <= wr.tsecond;
    end
    if (ctl.en_mem) begin
      entry_first  <= tbl_first[idx];
      entry_second <= tbl_second[idx];
    end
  end

  // Vector banks for elements 2*LANE and 2*LANE+1 of each tile column
  always_ff @(posedge clk) begin
    if (ctl.vec_we && wr.vidx[POS_W-1:0] == EVEN_POS)
      bank_even[BANK_AW'(wr.vidx[VIDX_W-1:POS_W])] <= wr.vval;
    if (ctl.vec_we && wr.vidx[POS_W-1:0] == ODD_POS)
      bank_odd[BANK_AW'(wr.vidx[VIDX_W-1:POS_W])] <= wr.vval;
    if (ctl.en_mem) begin
      vec_even <= bank_even[BANK_AW'(col)];
      vec_odd  <= bank_odd[BANK_AW'(col)];
      even_ok  <= 32'({col, EVEN_POS}) < VECTOR_DEPTH;
      odd_ok   <= 32'({col, ODD_POS}) < VECTOR_DEPTH;
    end
  end

  // Scale the table pair; zero elements beyond the vector
  always_ff @(posedge clk) begin
    if (ctl.en_scale) begin
      wsc_first  <= $signed(entry_first) * $signed({1'b0, scale});
      wsc_second <= $signed(entry_second) * $signed({1'b0, scale});
      ve         <= even_ok ? $signed(vec_even) : '0;
      vo         <= odd_ok ? $signed(vec_odd) : '0;
    end
  end

  // Floor shift, then multiply by the element
  assign wgt_first  = WGT_W'(wsc_first >>> FRAC_SH);
  assign wgt_second = WGT_W'(wsc_second >>> FRAC_SH);

  always_ff @(posedge clk) begin
    if (ctl.en_mult) begin
      prod_first  <= wgt_first * ve;
      prod_second <= wgt_second * vo;
    end
  end

endmodule

// ===== rtl/core/tdm_merge.sv =====
// Merge stage: registered tree that folds the lane products into one saturating step,
// then the row accumulators. Depends on tdm_pkg.
module tdm_merge
  import tdm_pkg::*;
#(
  parameter int LEAVES = 2 * LANES,
  parameter int LEVELS = $clog2(2 * LANES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [LEVELS-1:0]            lvl_en,
  input  logic [LEAVES-1:0][PROD_W-1:0] prods,
  input  logic                         apply_en,
  input  logic [ROW_W-1:0]             apply_row,
  input  logic                         apply_last,
  output logic signed [SUM_W-1:0]      sum
);

  node_t leaf_node [LEAVES];
  node_t node      [LEAVES-1];

  logic signed [SUM_W-1:0]  row_sums [TILE_DIM];
  logic signed [NODE_W-1:0] total;

  // Leaves in accumulation order
  generate
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      assign leaf_node[i] = leaf(prods[i]);
    end

    // Internal nodes, one register level per tree depth
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      localparam int LC = 2 * n + 1;
      localparam int RC = 2 * n + 2;
      localparam int D  = $clog2(n + 2) - 1;
      if (LC >= LEAVES - 1) begin : g_from_leaf
        always_ff @(posedge clk) begin
          if (lvl_en[D])
            node[n] <= combine(leaf_node[LC-(LEAVES-1)], leaf_node[RC-(LEAVES-1)]);
        end
      end else begin : g_from_node
        always_ff @(posedge clk) begin
          if (lvl_en[D]) node[n] <= combine(node[LC], node[RC]);
        end
      end
    end
  endgenerate

  // Apply the folded chain to the row accumulator
  assign total = NODE_W'(row_sums[apply_row]) + node[0].a;
  assign sum   = SUM_W'(clamp(total, node[0].l, node[0].h));

  // Update or clear the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < TILE_DIM; r++) row_sums[r] <= '0;
    end else if (apply_en) begin
      row_sums[apply_row] <= apply_last ? '0 : sum;
    end
  end

endmodule

// ===== rtl/core/trellis_weight_decode_matvec.sv =====
// Top level of the trellis weight decode matvec block: input stage, lane array,
// merge stage and result register. Depends on tdm_pkg, tdm_lane and tdm_merge.
//
// Takes one transaction per clock when not stalled. A trellis row goes through eight
// lanes, one per trellis state, each holding its own copy of the 1024-pair weight table
// and two of the sixteen vector banks, so all sixteen products of a row are formed in
// the same cycle; a four-level registered tree folds them into one saturating update of
// the row sum. Only rows with last_column set give a result; the pipeline keeps taking
// transactions while a result waits until all stages are full. Table and vector writes
// take effect in order with the rows around them. Storage is not cleared after reset;
// the row accumulators start at zero and the scale at 1.0.
module trellis_weight_decode_matvec
  import tdm_pkg::*;
#(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               scale_we,
  input  logic [SCALE_W-1:0] scale_wdata
);

  localparam int STAGES = 8;
  localparam int LEVELS = $clog2(2 * LANES);

  logic [SCALE_W-1:0] scale;

  logic [STAGES:1] v;
  logic [STAGES:1] rdy;
  logic            out_free;
  logic            apply_en;

  kind_t             kind1;
  wr_t               wr1;
  logic [COL_W-1:0]  col1;
  logic [ROW_W-1:0]  row_p  [1:STAGES];
  logic              last_p [1:STAGES];

  lane_ctl_t                     ctl;
  logic [2*LANES-1:0][PROD_W-1:0] prods;
  logic [LEVELS-1:0]             lvl_en;
  logic signed [SUM_W-1:0]       sum;

  // Scale register
  always_ff @(posedge clk) begin
    if (rst) scale <= SCALE_RESET;
    else if (scale_we) scale <= scale_wdata;
  end

  // Stage advance: a stage loads when empty or when its contents move on
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    rdy[STAGES] = !v[STAGES] || !last_p[STAGES] || out_free;
    for (int k = STAGES - 1; k >= 1; k--) rdy[k] = !v[k] || rdy[k+1];
  end

  assign item_stall = !rdy[1];
  assign apply_en   = v[STAGES] && rdy[STAGES];

  // Valid pipeline; drop unused kinds, keep writes only to the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1])
        v[1] <= item_valid && (item.kind == KIND_TABLE || item.kind == KIND_VECTOR ||
                               item.kind == KIND_ROW);
      if (rdy[2]) v[2] <= v[1] && kind1 == KIND_ROW;
      for (int k = 3; k <= STAGES; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      kind1       <= item.kind;
      wr1.tidx    <= item.table_index;
      wr1.tfirst  <= item.table_first_value;
      wr1.tsecond <= item.table_second_value;
      wr1.vidx    <= item.vector_index;
      wr1.vval    <= item.vector_value;
      col1        <= item.column;
      row_p[1]    <= item.row_in_tile;
      last_p[1]   <= item.last_column;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (rdy[k]) begin
        row_p[k]  <= row_p[k-1];
        last_p[k] <= last_p[k-1];
      end
    end
  end

  // Lane control
  assign ctl.en_idx   = rdy[1];
  assign ctl.en_mem   = rdy[2];
  assign ctl.en_scale = rdy[3];
  assign ctl.en_mult  = rdy[4];
  assign ctl.tbl_we   = rdy[2] && v[1] && kind1 == KIND_TABLE;
  assign ctl.vec_we   = rdy[2] && v[1] && kind1 == KIND_VECTOR &&
                        32'(wr1.vidx) < VECTOR_DEPTH;

  generate
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      tdm_lane #(
        .LANE         (l),
        .VECTOR_DEPTH (VECTOR_DEPTH)
      ) u_lane (
        .clk         (clk),
        .ctl         (ctl),
        .item        (item),
        .wr          (wr1),
        .col         (col1),
        .scale       (scale),
        .prod_first  (prods[2*l]),
        .prod_second (prods[2*l+1])
      );
    end

    // Tree depth d registers with the stage that ends d levels before the root
    for (genvar d = 0; d < LEVELS; d++) begin : g_lvl
      assign lvl_en[d] = rdy[STAGES-d];
    end
  endgenerate

  tdm_merge #(
    .LEAVES (2 * LANES),
    .LEVELS (LEVELS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .lvl_en     (lvl_en),
    .prods      (prods),
    .apply_en   (apply_en),
    .apply_row  (row_p[STAGES]),
    .apply_last (last_p[STAGES]),
    .sum        (sum)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (out_free) result_valid <= v[STAGES] && last_p[STAGES];
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result.out_row <= row_p[STAGES];
      result.row_sum <= sum;
    end
  end

endmodule

// ===== bench/tdm_checker.sv =====
// Checker for the trellis weight decode matvec block: watches both channels and the scale port.
// Predicts each row sum from its own copy of table, vector and accumulators. Depends on tdm_pkg.
module tdm_checker
  import tdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  item_t              item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  result_t            result,
  input  logic               scale_we,
  input  logic [SCALE_W-1:0] scale_wdata,
  output int                 pending,
  output int                 fails
);

  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic [WORD_W-1:0]  pair_first [TABLE_ENTRIES];
  logic [WORD_W-1:0]  pair_second[TABLE_ENTRIES];
  logic [WORD_W-1:0]  vec_mem    [VECTOR_DEPTH_DEF];
  longint             row_acc    [TILE_DIM];
  logic [SCALE_W-1:0] scale;
  result_t            sums_due[$];

  initial fails = 0;
  assign pending = sums_due.size();

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fails++;
  endtask

  // floor(entry * scale / 256): arithmetic shift floors toward minus infinity
  function automatic longint scaled_weight(input logic [WORD_W-1:0] entry);
    longint p;
    p = longint'($signed(entry)) * longint'(scale);
    return p >>> FRAC_SH;
  endfunction

  function automatic longint sat_add(input longint acc, input longint add);
    longint s;
    s = acc + add;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Even state is word w; odd state joins word w low byte with the next high byte
  function automatic logic [WORD_W-1:0] trellis_state(input logic [ROWS_W-1:0] words,
                                                      input logic [BYTE_W-1:0] next_hi,
                                                      input int k);
    int w;
    logic [BYTE_W-1:0] hi;
    w = k / 2;
    if (k % 2 == 0) return words[16*w +: 16];
    hi = (w == 3) ? next_hi : words[16*(w+1) + 8 +: 8];
    return {words[16*w +: 8], hi};
  endfunction

  task automatic absorb(input item_t it);
    longint acc;
    logic [WORD_W-1:0] s;
    logic [31:0] sq;
    logic [TIDX_W-1:0] t;
    int base;
    result_t r;
    case (it.kind)
      KIND_TABLE: begin
        pair_first[it.table_index]  = it.table_first_value;
        pair_second[it.table_index] = it.table_second_value;
      end
      KIND_VECTOR: vec_mem[it.vector_index] = it.vector_value;
      KIND_ROW: begin
        acc  = row_acc[it.row_in_tile];
        base = int'(it.column) * TILE_DIM;
        for (int k = 0; k < LANES; k++) begin
          s   = trellis_state(it.row_words, it.next_row_high_byte, k);
          sq  = 32'(s) * (32'(s) + 32'd1);
          t   = sq[6 +: TIDX_W];
          acc = sat_add(acc, scaled_weight(pair_first[t]) *
                             longint'($signed(vec_mem[base + 2*k])));
          acc = sat_add(acc, scaled_weight(pair_second[t]) *
                             longint'($signed(vec_mem[base + 2*k + 1])));
        end
        if (it.last_column) begin
          r.out_row = it.row_in_tile;
          r.row_sum = acc[SUM_W-1:0];
          sums_due.push_back(r);
          row_acc[it.row_in_tile] = 0;
        end else begin
          row_acc[it.row_in_tile] = acc;
        end
      end
      default: ;
    endcase
  endtask

  // Track config, accepted items and accepted results at each edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      scale = SCALE_RESET;
      foreach (row_acc[i]) row_acc[i] = 0;
    end else begin
      if (scale_we) scale = scale_wdata;
      if (item_valid && !item_stall) absorb(item);
      if (result_valid && !result_stall) begin
        if (sums_due.size() == 0) begin
          report($sformatf("unexpected result row %0d sum %0d",
                           result.out_row, result.row_sum));
        end else begin
          want = sums_due.pop_front();
          if (result.out_row !== want.out_row)
            report($sformatf("out_row got %0d want %0d", result.out_row, want.out_row));
          if (result.row_sum !== want.row_sum)
            report($sformatf("row_sum row %0d got %0d want %0d",
                             want.out_row, result.row_sum, want.row_sum));
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the trellis weight decode matvec block.
// Depends on tdm_pkg, trellis_weight_decode_matvec and tdm_checker.
module testbench;
  import tdm_pkg::*;

  localparam kind_t KIND_UNUSED = kind_t'(2'd3);
  localparam int    LIMIT       = 1000000;
  localparam int    SETTLE      = 20;

  logic               clk = 0;
  logic               rst = 1;
  logic               item_valid = 0;
  logic               item_stall;
  item_t              item = '0;
  logic               result_valid;
  logic               result_stall = 0;
  result_t            result;
  logic               scale_we = 0;
  logic [SCALE_W-1:0] scale_wdata = '0;
  int                 pending;
  int                 fails;
  int                 cycles = 0;
  int                 rx_wait = 0;
  bit                 quiet = 1;

  // Rows are built from these bytes and columns only, so every read entry is written
  logic [BYTE_W-1:0]  alpha [8];
  logic [COL_W-1:0]   cols  [4];

  always #2 clk = ~clk;

  trellis_weight_decode_matvec u_top (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .scale_we, .scale_wdata
  );

  tdm_checker u_checker (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .scale_we, .scale_wdata, .pending, .fails
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold result stall for a drawn number of cycles after each result transaction
  always @(posedge clk) begin
    int nxt;
    nxt = rx_wait;
    if (!rst && result_valid && !result_stall) nxt = quiet ? 0 : $urandom_range(0, 16);
    else if (nxt > 0) nxt--;
    rx_wait <= nxt;
    result_stall <= (nxt != 0);
  end

  task automatic send(input item_t it);
    int gap;
    bit took;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1;
    do begin
      @(negedge clk);
      took = !item_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Drain all expected sums and let in-flight writes retire
  task automatic settle();
    item_valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    settle();
    scale_we <= 1;
    scale_wdata <= v;
    @(posedge clk);
    scale_we <= 0;
  endtask

  function automatic logic [TIDX_W-1:0] table_slot(input logic [WORD_W-1:0] s);
    logic [31:0] sq;
    sq = 32'(s) * (32'(s) + 32'd1);
    return sq[6 +: TIDX_W];
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    return alpha[$urandom_range(0, 7)];
  endfunction

  function automatic logic [ROWS_W-1:0] pick_words();
    logic [ROWS_W-1:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = pick_byte();
    return w;
  endfunction

  function automatic item_t noise();
    item_t it;
    it.kind               = kind_t'($urandom_range(0, 3));
    it.table_index        = TIDX_W'($urandom);
    it.table_first_value  = WORD_W'($urandom);
    it.table_second_value = WORD_W'($urandom);
    it.vector_index       = VIDX_W'($urandom);
    it.vector_value       = WORD_W'($urandom);
    it.row_words          = {$urandom, $urandom};
    it.next_row_high_byte = BYTE_W'($urandom);
    it.row_in_tile        = ROW_W'($urandom);
    it.column             = COL_W'($urandom);
    it.last_column        = 1'($urandom);
    return it;
  endfunction

  task automatic put_table(input int idx, input logic [15:0] a, input logic [15:0] b);
    item_t it;
    it = noise();
    it.kind = KIND_TABLE;
    it.table_index = TIDX_W'(idx);
    it.table_first_value = a;
    it.table_second_value = b;
    send(it);
  endtask

  task automatic put_vector(input int idx, input logic [15:0] v);
    item_t it;
    it = noise();
    it.kind = KIND_VECTOR;
    it.vector_index = VIDX_W'(idx);
    it.vector_value = v;
    send(it);
  endtask

  task automatic put_row(input logic [63:0] w, input logic [7:0] nh, input int row,
                         input int col, input bit last);
    item_t it;
    it = noise();
    it.kind = KIND_ROW;
    it.row_words = w;
    it.next_row_high_byte = nh;
    it.row_in_tile = ROW_W'(row);
    it.column = COL_W'(col);
    it.last_column = last;
    send(it);
  endtask

  // Mostly rows, with table rewrites, vector rewrites and unused kinds mixed in
  task automatic random_burst(input int n);
    item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      it = noise();
      pick = $urandom_range(0, 99);
      if (pick < 15) it.kind = KIND_TABLE;
      else if (pick < 27) it.kind = KIND_VECTOR;
      else if (pick < 32) it.kind = KIND_UNUSED;
      else begin
        it.kind = KIND_ROW;
        it.row_words = pick_words();
        it.next_row_high_byte = pick_byte();
        it.column = cols[$urandom_range(0, 3)];
        it.last_column = ($urandom_range(0, 2) == 0);
      end
      send(it);
    end
  endtask

  // Drive a column-0 row of all-zero states into one accumulator until it clamps
  task automatic saturate(input int row, input logic [15:0] v);
    for (int i = 0; i < 16; i++) put_vector(i, v);
    for (int i = 0; i < 40; i++) put_row(64'd0, 8'd0, row, 0, 0);
    put_row(64'd0, 8'd0, row, 0, 1);
  endtask

  initial begin
    alpha[0] = 8'h00;
    alpha[1] = 8'hFF;
    alpha[2] = 8'h80;
    alpha[3] = 8'h7F;
    for (int i = 4; i < 8; i++) alpha[i] = BYTE_W'($urandom);
    cols[0] = 8'd0;
    cols[1] = 8'd1;
    cols[2] = 8'd128;
    cols[3] = 8'd255;

    repeat (11) @(posedge clk);
    rst <= 0;
    write_scale(SCALE_RESET);

    // Write every table pair and vector element that a row can read
    quiet = 1;
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        put_table(int'(table_slot({alpha[a], alpha[b]})), 16'($urandom), 16'($urandom));
    for (int c = 0; c < 4; c++)
      for (int e = 0; e < TILE_DIM; e++)
        put_vector(int'(cols[c]) * TILE_DIM + e, 16'($urandom));

    // Directed: field extremes, unused kind, partial and final columns
    quiet = 0;
    put_table(TABLE_ENTRIES - 1, 16'h8000, 16'h7FFF);
    put_table(0, 16'h7FFF, 16'h8000);
    put_vector(VECTOR_DEPTH_DEF - 1, 16'h8000);
    put_vector(0, 16'h7FFF);
    put_row(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 15, 255, 1);
    put_row(64'd0, 8'd0, 0, 0, 1);
    put_row(64'h7F80_00FF_807F_FF00, 8'h80, 7, 1, 0);
    put_row(64'hFF00_7F80_0080_FF7F, 8'h7F, 7, 128, 1);
    begin
      item_t it;
      it = noise();
      it.kind = KIND_UNUSED;
      send(it);
    end
    put_row(64'd0, 8'd0, 2, 0, 0);
    put_row(64'd0, 8'd0, 2, 0, 1);

    random_burst(160);
    write_scale(16'd0);
    random_burst(50);

    // Clamp both ways at the largest scale
    write_scale(16'hFFFF);
    put_table(0, 16'h8000, 16'h8000);
    saturate(3, 16'h8000);
    saturate(9, 16'h7FFF);
    random_burst(110);

    write_scale(SCALE_W'($urandom));
    random_burst(80);

    settle();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tdm_pkg.sv
rtl/core/tdm_lane.sv
rtl/core/tdm_merge.sv
rtl/core/trellis_weight_decode_matvec.sv
bench/tdm_checker.sv
bench/testbench.sv
